>>> rtl/fnbd_pkg.sv
// Shared constants, register codes and derived widths for the fire blur block.
// Standalone package; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fnbd_pkg;

  localparam int unsigned WIDTH  = 256;
  localparam int unsigned HEIGHT = 256;

  localparam int unsigned CW   = $clog2(WIDTH);
  localparam int unsigned RW   = $clog2(HEIGHT);
  localparam int unsigned PW   = 8;
  localparam int unsigned BW   = 8;
  localparam int unsigned MW   = 9;
  localparam int unsigned CMPW = ((CW > MW) ? CW : MW) + 2;
  localparam int unsigned SW   = PW + 3;
  localparam int unsigned IDXW = 1;
  localparam int unsigned CDW  = 9;

  localparam logic [IDXW-1:0] REG_BURN   = IDXW'(0);
  localparam logic [IDXW-1:0] REG_MARGIN = IDXW'(1);

  localparam logic [BW-1:0] BURN_RST   = BW'(2);
  localparam logic [MW-1:0] MARGIN_RST = MW'(112);

  typedef logic [PW-1:0] pix_t;

endpackage

`default_nettype wire

>>> rtl/fnbd_line_mem.sv
// Two-port synchronous line store: one write port, one registered read port.
// A read of the address written in the same cycle returns the new data.
`timescale 1ns / 1ps
`default_nettype none

module fnbd_line_mem #(
  parameter int unsigned DW    = 16,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/fire_neighbour_blur_decay.sv
// Fire-effect blur with decay: top level.
// Depends on fnbd_pkg and fnbd_line_mem.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one old-frame heat pixel per
//   beat in raster order, WIDTH per row; frame_start_i marks pixel (0,0).
//   Output channel (out_valid_o/out_ready_i) gives zero or one new pixel per
//   input beat: the 8-neighbour mean minus burn, floored at zero, placed one
//   row above its centre. frame_done_o flags the last result of a frame.
//   Config channel (cfg_valid_i/cfg_ready_o) writes burn (index 0) and
//   margin (index 1); it is always ready and is meant for idle periods.
// Throughput: one pixel per cycle while the output is not held, as the
//   combined line store has one read port and one write port.
// Pipeline: working stage, then output register for the result.
// Reset: counters, window and valid flags clear at once; burn goes to 2 and
//   margin to 112. Line store contents are undefined until written.
// Stall: with the output held, at most one more pixel enters the working
//   stage, then in_ready_o drops until the output beat completes.
`timescale 1ns / 1ps
`default_nettype none

module fire_neighbour_blur_decay
  import fnbd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [PW-1:0]   heat_in_i,
  input  wire logic            frame_start_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_x_o,
  output logic [7:0]           out_y_o,
  output logic [PW-1:0]        heat_out_o,
  output logic                 frame_done_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [IDXW-1:0] cfg_index_i,
  input  wire logic [CDW-1:0]  cfg_data_i
);

  logic [BW-1:0] burn_q;
  logic [MW-1:0] margin_q;

  logic [CW-1:0] col_q, col_d, c_cur;
  logic [RW-1:0] row_q, row_d, r_cur;

  logic          s1_valid_q;
  pix_t          s1_pix_q;
  logic [CW-1:0] s1_c_q;
  logic [RW-1:0] s1_r_q;

  pix_t w1_q [3];
  pix_t w2_q [3];

  logic           out_valid_q;
  logic [7:0]     out_x_q, out_y_q;
  pix_t           out_heat_q;
  logic           out_done_q;

  logic           in_fire, s1_fire, s1_hit;
  logic [2*PW-1:0] rd_data;
  pix_t           top, mid;
  logic [SW-1:0]  sum;
  pix_t           avg, heat;
  logic [CW-1:0]  x;
  logic [RW-1:0]  y_m1;
  logic [CMPW-1:0] x_ext, m_ext;
  logic           x_ok, y_ok, done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burn_q   <= BURN_RST;
      margin_q <= MARGIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BURN:   burn_q   <= cfg_data_i[BW-1:0];
        REG_MARGIN: margin_q <= cfg_data_i[MW-1:0];
        default: ;
      endcase
    end
  end

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    c_cur = frame_start_i ? '0 : col_q;
    r_cur = frame_start_i ? '0 : row_q;
    col_d = c_cur;
    row_d = r_cur;
    if (c_cur == CW'(WIDTH - 1)) begin
      col_d = '0;
      row_d = (r_cur == RW'(HEIGHT - 1)) ? '0 : r_cur + RW'(1);
    end else begin
      col_d = c_cur + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q <= heat_in_i;
      s1_c_q   <= c_cur;
      s1_r_q   <= r_cur;
    end
  end

  fnbd_line_mem #(
    .DW    (2 * PW),
    .DEPTH (WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_c_q),
    .wr_data_i ({mid, s1_pix_q}),
    .rd_en_i   (in_fire),
    .rd_addr_i (c_cur),
    .rd_data_o (rd_data)
  );

  assign top = rd_data[2*PW-1:PW];
  assign mid = rd_data[PW-1:0];

  always_comb begin
    sum = SW'(w2_q[0]) + SW'(w2_q[1]) + SW'(w2_q[2]) + SW'(w1_q[0]) + SW'(w1_q[2])
        + SW'(top) + SW'(mid) + SW'(s1_pix_q);
    avg  = sum[SW-1:3];
    heat = (avg < burn_q) ? '0 : avg - burn_q;
    x     = s1_c_q - CW'(1);
    y_m1  = s1_r_q - RW'(2);
    x_ext = CMPW'(x);
    m_ext = CMPW'(margin_q);
    y_ok  = (s1_r_q >= RW'(3)) && (s1_r_q <= RW'(HEIGHT - 2));
    x_ok  = (s1_c_q != '0) && (x_ext >= m_ext)
         && ((x_ext + m_ext + CMPW'(1)) < CMPW'(WIDTH));
    done  = (s1_r_q == RW'(HEIGHT - 2)) && ((x_ext + m_ext + CMPW'(2)) == CMPW'(WIDTH));
  end

  assign s1_hit = x_ok && y_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        w1_q[i] <= '0;
        w2_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        for (int i = 0; i < 3; i++) begin
          w2_q[i] <= (s1_c_q == '0) ? '0 : w1_q[i];
        end
        w1_q[0] <= top;
        w1_q[1] <= mid;
        w1_q[2] <= s1_pix_q;
      end
      if (s1_fire) begin
        out_valid_q <= s1_hit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_hit) begin
      out_x_q    <= 8'(x);
      out_y_q    <= 8'(y_m1);
      out_heat_q <= heat;
      out_done_q <= done;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign heat_out_o   = out_heat_q;
  assign frame_done_o = out_done_q;

endmodule

`default_nettype wire

>>> rtl/fnbd_checker.sv
// Port-level checks for the fire blur top level, attached by bind.
// Depends on fnbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnbd_checker
  import fnbd_pkg::*;
(
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire logic [7:0]    out_x_o,
  input wire logic [7:0]    out_y_o,
  input wire logic [PW-1:0] heat_out_o,
  input wire logic          frame_done_o
);

  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output free");

  a_done_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> (out_y_o == 8'(HEIGHT - 4)))
    else $error("frame_done on wrong row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_x_o)
      && $stable(out_y_o) && $stable(heat_out_o) && $stable(frame_done_o)))
    else $error("output beat changed while stalled");

endmodule

bind fire_neighbour_blur_decay fnbd_checker u_fnbd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_x_o      (out_x_o),
  .out_y_o      (out_y_o),
  .heat_out_o   (heat_out_o),
  .frame_done_o (frame_done_o)
);

`default_nettype wire

>>> tb/fire_neighbour_blur_decay_tb.sv
// Self-checking bench for fire_neighbour_blur_decay: streams heat frames with random
// gaps and output stalls, predicts every blurred pixel and checks each output beat.
// Depends on fnbd_pkg and the fire_neighbour_blur_decay RTL.
`timescale 1ns / 1ps

module fire_neighbour_blur_decay_tb;
  import fnbd_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned RAND_PIXELS = 1250;
  localparam int unsigned RAND_BLURS  = 48;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    pix_t       heat;
    logic       done;
  } blur_px_t;

  typedef struct packed {
    logic [BW-1:0] burn;
    logic [MW-1:0] margin;
    logic [17:0]   count;
    logic          rnd;
    pix_t          level;
    logic          fixed;
    pix_t          fixed_heat;
  } seg_t;

  typedef enum int unsigned {FILL_ANY, FILL_HOT, FILL_COOL} fill_e;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [PW-1:0]   heat_in_i;
  logic            frame_start_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [7:0]      out_x_o;
  logic [7:0]      out_y_o;
  logic [PW-1:0]   heat_out_o;
  logic            frame_done_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [IDXW-1:0] cfg_index_i;
  logic [CDW-1:0]  cfg_data_i;

  pix_t        row_above [WIDTH];
  pix_t        row_above2 [WIDTH];
  pix_t        win [6];
  int unsigned col_q;
  int unsigned row_q;
  int unsigned burn_q;
  int unsigned margin_q;
  blur_px_t    due_q [$];

  int unsigned errors       = 0;
  int unsigned results_seen = 0;
  int unsigned calm_left    = 0;
  int unsigned stall_left   = 0;
  int unsigned idle_cycles  = 0;
  bit          typed_on     = 1'b0;
  pix_t        typed_heat   = '0;

  fire_neighbour_blur_decay dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .heat_in_i     (heat_in_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .heat_out_o    (heat_out_o),
    .frame_done_o  (frame_done_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit blur_pixel(input pix_t pix, input logic fs, output blur_px_t res);
    int unsigned c, r, x, y, sum, heat;
    pix_t top, mid;
    bit hit;
    hit = 1'b0;
    res = '0;
    if (fs) begin
      col_q = 0;
      row_q = 0;
    end
    c = col_q;
    r = row_q;
    top = row_above2[c];
    mid = row_above[c];
    if (c >= 1 && r >= 1) begin
      x = c - 1;
      y = r - 1;
      if (y >= 2 && y + 2 < HEIGHT && x >= margin_q && x + 1 + margin_q < WIDTH) begin
        sum = win[3] + win[4] + win[5] + win[0] + win[2] + top + mid + pix;
        heat = sum >> 3;
        heat = (heat < burn_q) ? 0 : heat - burn_q;
        res.x = 8'(x);
        res.y = 8'(y - 1);
        res.heat = pix_t'(heat);
        res.done = (y + 3 == HEIGHT) && (x + 2 + margin_q == WIDTH);
        hit = 1'b1;
      end
    end
    // clear the older column at a row start
    if (c == 0) begin
      win[3] = '0;
      win[4] = '0;
      win[5] = '0;
    end else begin
      win[3] = win[0];
      win[4] = win[1];
      win[5] = win[2];
    end
    win[0] = top;
    win[1] = mid;
    win[2] = pix;
    row_above2[c] = mid;
    row_above[c] = pix;
    c++;
    if (c >= WIDTH) begin
      c = 0;
      r++;
      if (r >= HEIGHT) r = 0;
    end
    col_q = c;
    row_q = r;
    return hit;
  endfunction

  function automatic pix_t pick_pixel(input fill_e fill);
    case (fill)
      FILL_HOT:  return pix_t'($urandom_range(160, 255));
      FILL_COOL: return pix_t'($urandom_range(0, 63));
      default:   return pix_t'($urandom);
    endcase
  endfunction

  task automatic report(input string what, input blur_px_t got, input blur_px_t want);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("%s: got x=%0d y=%0d heat=%0d done=%0b, expected x=%0d y=%0d heat=%0d done=%0b",
               what, got.x, got.y, got.heat, got.done, want.x, want.y, want.heat, want.done);
  endtask

  always @(posedge clk_i) begin
    blur_px_t want, got;
    if (!rst_ni) begin
      foreach (row_above[i]) begin
        row_above[i] = '0;
        row_above2[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_q = 0;
      row_q = 0;
      burn_q = BURN_RST;
      margin_q = MARGIN_RST;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BURN:   burn_q = cfg_data_i[BW-1:0];
          REG_MARGIN: margin_q = cfg_data_i[MW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        if (blur_pixel(heat_in_i, frame_start_i, want)) begin
          if (typed_on) want.heat = typed_heat;
          due_q.push_back(want);
        end
      end
      if (out_valid_o && out_ready_i) begin
        got = {out_x_o, out_y_o, heat_out_o, frame_done_o};
        results_seen++;
        if (due_q.size() == 0) begin
          report("unexpected beat", got, '0);
        end else begin
          want = due_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.heat !== want.heat ||
              got.done !== want.done)
            report("mismatch", got, want);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (calm_left != 0) calm_left <= calm_left - 1;
    else if ($urandom_range(0, 599) == 0) calm_left <= $urandom_range(100, 400);
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm_left == 0 && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[fire_neighbour_blur_decay] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // drop valid, let the pipeline drain and wait for every due pixel
  task automatic settle();
    in_valid_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    while (due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic push_pixel(input pix_t pix, input logic fs);
    int unsigned gap, roll;
    roll = $urandom_range(0, 99);
    gap = 0;
    if (calm_left == 0 && roll >= 70)
      gap = (roll < 95) ? $urandom_range(1, 3) : $urandom_range(4, 24);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    heat_in_i <= pix;
    frame_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic apply_cfg(input int unsigned burn_v, input int unsigned margin_v);
    logic [IDXW-1:0] idx [2];
    int unsigned val [2];
    bit [1:0] dirty;
    idx[0] = REG_BURN;
    idx[1] = REG_MARGIN;
    val[0] = burn_v;
    val[1] = margin_v;
    dirty = {margin_v != margin_q, burn_v != burn_q};
    if (dirty != 0) begin
      settle();
      for (int i = 0; i < 2; i++) begin
        if (dirty[i]) begin
          cfg_valid_i <= 1'b1;
          cfg_index_i <= idx[i];
          cfg_data_i <= CDW'(val[i]);
          do @(posedge clk_i); while (!cfg_ready_o);
        end
      end
      cfg_valid_i <= 1'b0;
    end
  endtask

  initial begin
    seg_t plan [10];
    int unsigned burn_v, margin_v, count, base, fed;
    fill_e fill;
    bit well_formed;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    heat_in_i = '0;
    frame_start_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    // burn, margin, pixels, random fill, level, typed heat valid, typed heat
    plan = '{
      '{8'd2,   9'd112, 18'd1024,  1'b0, 8'd200, 1'b1, 8'd198},
      '{8'd0,   9'd1,   18'd1024,  1'b0, 8'd255, 1'b1, 8'd255},
      '{8'd255, 9'd0,   18'd1024,  1'b0, 8'd255, 1'b1, 8'd0},
      '{8'd0,   9'd0,   18'd1024,  1'b1, 8'd0,   1'b0, 8'd0},
      '{8'd3,   9'd127, 18'd1024,  1'b1, 8'd0,   1'b0, 8'd0},
      '{8'd3,   9'd128, 18'd1024,  1'b1, 8'd0,   1'b0, 8'd0},
      '{8'd3,   9'd256, 18'd1024,  1'b1, 8'd0,   1'b0, 8'd0},
      '{8'd5,   9'd60,  18'd1000,  1'b1, 8'd0,   1'b0, 8'd0},
      '{8'd5,   9'd60,  18'd1100,  1'b1, 8'd0,   1'b0, 8'd0},
      '{8'd1,   9'd100, 18'd66560, 1'b1, 8'd0,   1'b0, 8'd0}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      settle();
      apply_cfg(plan[i].burn, plan[i].margin);
      typed_on = plan[i].fixed;
      typed_heat = plan[i].fixed_heat;
      for (int k = 0; k < plan[i].count; k++)
        push_pixel(plan[i].rnd ? pick_pixel(FILL_ANY) : plan[i].level, k == 0);
    end

    settle();
    typed_on = 1'b0;
    base = results_seen;
    fed = 0;
    while (fed < RAND_PIXELS || results_seen - base < RAND_BLURS) begin
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0:       burn_v = 0;
          1:       burn_v = 255;
          2, 3:    burn_v = $urandom_range(0, 255);
          default: burn_v = $urandom_range(0, 7);
        endcase
        case ($urandom_range(0, 9))
          0:       margin_v = 0;
          1:       margin_v = 256;
          2:       margin_v = $urandom_range(127, 256);
          default: margin_v = $urandom_range(0, 120);
        endcase
        apply_cfg(burn_v, margin_v);
      end
      fill = fill_e'($urandom_range(0, 2));
      well_formed = ($urandom_range(0, 4) != 0);
      count = well_formed ? $urandom_range(768, 1300) : $urandom_range(1, 200);
      for (int k = 0; k < count; k++)
        push_pixel(pick_pixel(fill), well_formed ? (k == 0) : ($urandom_range(0, 31) == 0));
      fed += count;
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0)
      $display("[fire_neighbour_blur_decay] OK");
    else
      $display("[fire_neighbour_blur_decay] ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/fnbd_pkg.sv
rtl/fnbd_line_mem.sv
rtl/fire_neighbour_blur_decay.sv
rtl/fnbd_checker.sv
tb/fire_neighbour_blur_decay_tb.sv
